// ----- hdl/edf_pkg.sv -----
// Shared types, codes and helpers of the EDF periodic task scheduler.
// No dependencies; the files that use it refer to it by scoped names.
package edf_pkg;

   // Item kinds on the request channel
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Event codes on the response channel
   localparam logic [2:0] EV_START   = 3'd0;
   localparam logic [2:0] EV_END     = 3'd1;
   localparam logic [2:0] EV_PREEMPT = 3'd2;
   localparam logic [2:0] EV_MISS    = 3'd3;
   localparam logic [2:0] EV_IDLE    = 3'd4;
   localparam logic [2:0] EV_RAN     = 3'd5;
   localparam logic [2:0] EV_HORIZON = 3'd6;

   // Register indexes on the CSR port
   localparam logic CSR_TASK_COUNT = 1'b0;
   localparam logic CSR_HORIZON    = 1'b1;

   // Per-tick limits: passes of the decision loop and events emitted
   localparam int OUT_MAX  = 8;
   localparam int PASS_MAX = 8;

   typedef struct packed {
      logic        kind;
      logic [3:0]  task_index;
      logic [15:0] burst;
      logic [15:0] period;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [3:0]  task_res;
      logic [31:0] time_now;
      logic [15:0] units_left;
      logic [31:0] waiting_total;
      logic        last;
   } rsp_type;

   // One write into the response queue
   typedef struct packed {
      logic    en;
      rsp_type data;
   } push_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD,
      ST_RDRUN,
      ST_GETRUN,
      ST_SCAN,
      ST_DECIDE,
      ST_RELEASE,
      ST_SWITCH,
      ST_START,
      ST_ADVANCE,
      ST_NEXT,
      ST_FINISH
   } state_type;

   // Operation chosen by one pass of the decision loop
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_PICK,
      OP_RUN,
      OP_END,
      OP_REL,
      OP_MISS
   } op_type;

   function automatic rsp_type mk_rsp(logic [2:0] ev, logic [3:0] tsk, logic [31:0] t,
                                      logic [15:0] left, logic [31:0] wt);
      rsp_type r;
      r.event_res     = ev;
      r.task_res      = tsk;
      r.time_now      = t;
      r.units_left    = left;
      r.waiting_total = wt;
      r.last          = 1'b0;
      return r;
   endfunction

endpackage

// ----- hdl/edf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module edf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/edf_mod_unit.sv -----
// Restoring remainder unit: 32-bit dividend modulo a narrow divisor, one bit a cycle.
// No dependencies; used to seed a task's phase when its entry is loaded.
module edf_mod_unit #(
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] remainder
);

   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [31:0]   dvd_ff, dvd_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW:0]   shifted;

   // One restoring step per cycle
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      shifted   = {rem_ff, dvd_ff[31]};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = 6'd32;
         dvd_in    = dividend;
         div_in    = divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = DW'(shifted - {1'b0, div_ff});
         end else begin
            rem_in = DW'(shifted);
         end
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hdl/edf_rsp_fifo.sv -----
// Response queue holding the events of one tick until the consumer takes them.
// Depends on edf_pkg (rsp_type, push_type).
module edf_rsp_fifo #(
   parameter int DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  edf_pkg::push_type push,
   input  logic              pop,
   output logic              rsp_valid,
   output edf_pkg::rsp_type  rsp_data,
   output logic              empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   edf_pkg::rsp_type slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic             do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push.en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push.en && !do_pop) begin
         cnt_in = cnt_ff + NW'(1);
      end else if (!push.en && do_pop) begin
         cnt_in = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.en) begin
         slot_ff[wr_ptr_ff] <= push.data;
      end
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign empty     = (cnt_ff == '0);

endmodule

// ----- hdl/edf_periodic_task_scheduler.sv -----
// Top level of the EDF periodic task scheduler: CSRs, sequencer over the task RAM.
// Depends on edf_pkg, edf_ram, edf_mod_unit and edf_rsp_fifo.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | edf_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_ready  | edf_pkg::rsp_type
//   csr     | in/out    | APB psel/penable     | task_count, horizon
//
// A load item computes its phase one remainder bit per cycle, then writes the RAM.
// A tick runs up to 8 passes; each pass reads the running entry and scans the n
// active entries through the single RAM read port, a release adds a read-modify-write
// scan and a rescan, and the closing time step sweeps all MAX_TASKS entries.
// Reset is synchronous; RAM contents need none. A new item is taken only once the
// previous tick's events have all left the response queue.
module edf_periodic_task_scheduler #(
   parameter int MAX_TASKS  = 16,
   parameter int UNIT_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  edf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output edf_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int UW = UNIT_WIDTH;
   localparam int WW = 4 * UW;
   localparam logic [UW-1:0] UMAX = {UW{1'b1}};

   // Control state
   edf_pkg::state_type state_ff, state_in;
   logic [4:0]      tcount_ff, tcount_in;
   logic [31:0]     horizon_ff, horizon_in;
   logic [31:0]     clock_ff, clock_in;
   logic [31:0]     wait_ff, wait_in;
   logic            run_v_ff, run_v_in;
   logic [IW-1:0]   run_ff, run_in;
   logic [MAX_TASKS-1:0] valid_ff, valid_in;
   logic [3:0]      pass_ff, pass_in;
   logic [3:0]      ecnt_ff, ecnt_in;
   logic            released_ff, released_in;
   logic            post_ff, post_in;
   logic            post5_ff, post5_in;
   logic            dec_ff, dec_in;
   logic            pend_v_ff, pend_v_in;
   logic            dv_ff, dv_in;
   logic [CW-1:0]   idx_ff, idx_in;

   // Payload registers
   edf_pkg::rsp_type pend_ff, pend_in;
   logic [IW-1:0]   rd_idx_ff;
   logic [IW-1:0]   ld_idx_ff, ld_idx_in;
   logic [UW-1:0]   ld_burst_ff, ld_burst_in;
   logic [UW-1:0]   ld_period_ff, ld_period_in;
   logic [UW-1:0]   rn_units_ff, rn_units_in;
   logic [UW-1:0]   rn_dl_ff, rn_dl_in;
   logic            rn_bnd_ff, rn_bnd_in;
   logic            fnd_ff, fnd_in, fnd5_ff, fnd5_in;
   logic [IW-1:0]   ovd_ff, ovd_in;
   logic [UW-1:0]   ovd_units_ff, ovd_units_in;
   logic            nzany_ff, nzany_in;
   logic [CW-1:0]   wcnt_ff, wcnt_in;
   logic [IW-1:0]   c0_ff, c0_in;
   logic [UW-1:0]   dlc0_ff, dlc0_in;
   logic            minf_ff, minf_in;
   logic [UW-1:0]   minv_ff, minv_in;
   logic [IW-1:0]   fmin_ff, fmin_in;
   logic            uf_ff, uf_in, mf_ff, mf_in, nf_ff, nf_in;
   logic [IW-1:0]   ui_ff, ui_in, mi_ff, mi_in, ni_ff, ni_in;
   logic [UW-1:0]   nu_ff, nu_in;

   // RAM and helper unit wiring
   logic            wr_en;
   logic [IW-1:0]   wr_addr, rd_addr;
   logic [WW-1:0]   wr_data, rd_data;
   logic            mod_start, mod_done;
   logic [UW-1:0]   mod_div, mod_rem;
   edf_pkg::push_type push;
   logic            fifo_empty;

   // Decoded RAM word
   logic [UW-1:0]   w_burst, w_period, w_units, w_phase, w_peff, w_dl;
   logic [UW-1:0]   adv_phase, rel_units, adv_units;
   logic [UW:0]     rel_sum;
   logic            w_bnd;

   logic [CW-1:0]   n_tasks, limit;
   logic            scan_st, issue, scan_done;
   logic            req_acc, csr_wr, idx_ok, end_first;
   edf_pkg::op_type op;
   logic [IW-1:0]   pick_c, tgt;
   logic            sw;
   logic [32:0]     wsum;
   logic [31:0]     wait_new;
   logic [UW-1:0]   req_period;

   edf_ram #(.WIDTH(WW), .DEPTH(MAX_TASKS), .AW(IW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   edf_mod_unit #(.DW(UW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (clock_ff),
      .divisor   (mod_div),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   edf_rsp_fifo #(.DEPTH(edf_pkg::OUT_MAX)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .empty     (fifo_empty)
   );

   // Handshakes and CSR port
   assign req_ready  = (state_ff == edf_pkg::ST_IDLE) && fifo_empty;
   assign req_acc    = req_valid && req_ready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == edf_pkg::CSR_HORIZON) ? horizon_ff
                                                              : {27'd0, tcount_ff};

   always_comb begin
      tcount_in  = tcount_ff;
      horizon_in = horizon_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == edf_pkg::CSR_TASK_COUNT) begin
            tcount_in = csr_pwdata[4:0];
         end else begin
            horizon_in = csr_pwdata;
         end
      end
   end

   // Active entry count, clamped to the table size
   assign n_tasks = (32'(tcount_ff) > 32'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(tcount_ff);
   assign idx_ok  = 32'(req_data.task_index) < 32'(MAX_TASKS);
   assign req_period = UW'(req_data.period);
   assign mod_div    = (req_period == '0) ? UW'(1) : req_period;

   // Scan engine: one read issued per cycle, data in the next cycle
   assign scan_st = (state_ff == edf_pkg::ST_SCAN) || (state_ff == edf_pkg::ST_RELEASE) ||
                    (state_ff == edf_pkg::ST_ADVANCE);
   assign limit     = (state_ff == edf_pkg::ST_ADVANCE) ? CW'(MAX_TASKS) : n_tasks;
   assign issue     = scan_st && (idx_ff < limit);
   assign scan_done = scan_st && !issue && !dv_ff;
   assign rd_addr   = (state_ff == edf_pkg::ST_RDRUN) ? run_ff : idx_ff[IW-1:0];

   // RAM word fields: burst, period, units remaining, phase (time mod period)
   assign w_burst  = rd_data[4*UW-1:3*UW];
   assign w_period = rd_data[3*UW-1:2*UW];
   assign w_units  = valid_ff[rd_idx_ff] ? rd_data[2*UW-1:UW] : '0;
   assign w_phase  = rd_data[UW-1:0];
   assign w_peff   = (w_period == '0) ? UW'(1) : w_period;
   assign w_bnd    = (w_phase == '0);
   assign w_dl     = w_peff - w_phase;
   assign adv_phase = (w_phase == w_peff - UW'(1)) ? '0 : w_phase + UW'(1);
   assign rel_sum   = {1'b0, w_units} + {1'b0, w_burst};
   assign rel_units = w_bnd ? (rel_sum[UW] ? UMAX : rel_sum[UW-1:0]) : w_units;
   assign adv_units = (dec_ff && run_v_ff && rd_idx_ff == run_ff) ? w_units - UW'(1)
                                                                  : w_units;

   // Operation of the current pass
   assign end_first = run_v_ff && rn_bnd_ff && (rn_units_ff == '0);
   always_comb begin
      if (!released_ff && fnd_ff) begin
         op = fnd5_ff ? edf_pkg::OP_MISS : edf_pkg::OP_REL;
      end else begin
         if (!run_v_ff) begin
            op = edf_pkg::OP_PICK;
         end else if (rn_units_ff != '0) begin
            op = edf_pkg::OP_RUN;
         end else begin
            op = edf_pkg::OP_END;
         end
         if (!nzany_ff) begin
            op = run_v_ff ? edf_pkg::OP_END : edf_pkg::OP_IDLE;
         end
      end
   end

   assign pick_c   = (dlc0_ff == minv_ff) ? c0_ff : fmin_ff;
   assign wsum     = {1'b0, wait_ff} + 33'(wcnt_ff);
   assign wait_new = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];

   // Preemption target after a release, with the tie-breaks on remaining units
   always_comb begin
      tgt = run_ff;
      sw  = 1'b0;
      if (post5_ff) begin
         if (uf_ff) begin
            tgt = ui_ff;
            sw  = 1'b1;
         end
      end else if (mf_ff) begin
         tgt = mi_ff;
         sw  = 1'b1;
      end else if (uf_ff) begin
         tgt = ui_ff;
         sw  = 1'b1;
      end else if (nf_ff) begin
         tgt = ni_ff;
         sw  = (nu_ff != '0);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         edf_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_data.kind == edf_pkg::KIND_LOAD) begin
                  state_in = idx_ok ? edf_pkg::ST_DIV : edf_pkg::ST_IDLE;
               end else if (clock_ff < horizon_ff) begin
                  state_in = edf_pkg::ST_RDRUN;
               end
            end
         end
         edf_pkg::ST_DIV:    if (mod_done) state_in = edf_pkg::ST_LOAD;
         edf_pkg::ST_LOAD:   state_in = edf_pkg::ST_IDLE;
         edf_pkg::ST_RDRUN:  state_in = edf_pkg::ST_GETRUN;
         edf_pkg::ST_GETRUN: state_in = edf_pkg::ST_SCAN;
         edf_pkg::ST_SCAN: begin
            if (scan_done) state_in = post_ff ? edf_pkg::ST_SWITCH : edf_pkg::ST_DECIDE;
         end
         edf_pkg::ST_DECIDE: begin
            case (op)
               edf_pkg::OP_IDLE: state_in = edf_pkg::ST_ADVANCE;
               edf_pkg::OP_RUN:  state_in = edf_pkg::ST_ADVANCE;
               edf_pkg::OP_PICK: state_in = edf_pkg::ST_NEXT;
               edf_pkg::OP_END:  state_in = edf_pkg::ST_NEXT;
               edf_pkg::OP_REL:  state_in = end_first ? edf_pkg::ST_NEXT
                                                      : edf_pkg::ST_RELEASE;
               default:          state_in = edf_pkg::ST_RELEASE;
            endcase
         end
         edf_pkg::ST_RELEASE: begin
            if (scan_done) state_in = run_v_ff ? edf_pkg::ST_RDRUN : edf_pkg::ST_NEXT;
         end
         edf_pkg::ST_SWITCH:  state_in = sw ? edf_pkg::ST_START : edf_pkg::ST_NEXT;
         edf_pkg::ST_START:   state_in = edf_pkg::ST_NEXT;
         edf_pkg::ST_ADVANCE: if (scan_done) state_in = edf_pkg::ST_FINISH;
         edf_pkg::ST_NEXT: begin
            if ((pass_ff + 4'd1 < 4'(edf_pkg::PASS_MAX)) &&
                (ecnt_ff < 4'(edf_pkg::OUT_MAX))) begin
               state_in = edf_pkg::ST_RDRUN;
            end else begin
               state_in = edf_pkg::ST_FINISH;
            end
         end
         edf_pkg::ST_FINISH: state_in = edf_pkg::ST_IDLE;
         default:            state_in = edf_pkg::ST_IDLE;
      endcase
   end

   // Datapath and event emission
   always_comb begin
      logic             em_en;
      edf_pkg::rsp_type em_data;
      em_en        = 1'b0;
      em_data      = edf_pkg::mk_rsp(edf_pkg::EV_IDLE, 4'd0, clock_ff, 16'd0, wait_ff);
      push.en      = 1'b0;
      push.data    = pend_ff;
      clock_in     = clock_ff;
      wait_in      = wait_ff;
      run_v_in     = run_v_ff;
      run_in       = run_ff;
      valid_in     = valid_ff;
      pass_in      = pass_ff;
      ecnt_in      = ecnt_ff;
      released_in  = released_ff;
      post_in      = post_ff;
      post5_in     = post5_ff;
      dec_in       = dec_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      dv_in        = issue;
      idx_in       = issue ? idx_ff + CW'(1) : idx_ff;
      ld_idx_in    = ld_idx_ff;
      ld_burst_in  = ld_burst_ff;
      ld_period_in = ld_period_ff;
      rn_units_in  = rn_units_ff;
      rn_dl_in     = rn_dl_ff;
      rn_bnd_in    = rn_bnd_ff;
      fnd_in = fnd_ff;  fnd5_in = fnd5_ff;  ovd_in = ovd_ff;  ovd_units_in = ovd_units_ff;
      nzany_in = nzany_ff;  wcnt_in = wcnt_ff;  c0_in = c0_ff;  dlc0_in = dlc0_ff;
      minf_in = minf_ff;  minv_in = minv_ff;  fmin_in = fmin_ff;
      uf_in = uf_ff;  ui_in = ui_ff;  mf_in = mf_ff;  mi_in = mi_ff;
      nf_in = nf_ff;  ni_in = ni_ff;  nu_in = nu_ff;
      mod_start = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = rd_idx_ff;
      wr_data   = {w_burst, w_period, rel_units, w_phase};

      case (state_ff)
         edf_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_data.kind == edf_pkg::KIND_LOAD) begin
                  mod_start    = idx_ok;
                  ld_idx_in    = IW'(req_data.task_index);
                  ld_burst_in  = UW'(req_data.burst);
                  ld_period_in = req_period;
               end else if (clock_ff >= horizon_ff) begin
                  push.en        = 1'b1;
                  push.data      = edf_pkg::mk_rsp(edf_pkg::EV_HORIZON, 4'd0, clock_ff,
                                                   16'd0, wait_ff);
                  push.data.last = 1'b1;
               end else begin
                  pass_in     = '0;
                  ecnt_in     = '0;
                  released_in = 1'b0;
                  post_in     = 1'b0;
                  pend_v_in   = 1'b0;
               end
            end
         end
         edf_pkg::ST_LOAD: begin
            wr_en    = 1'b1;
            wr_addr  = ld_idx_ff;
            wr_data  = {ld_burst_ff, ld_period_ff, {UW{1'b0}}, mod_rem};
            valid_in[ld_idx_ff] = 1'b1;
         end
         edf_pkg::ST_GETRUN: begin
            // running entry, then a fresh scan
            rn_units_in = w_units;
            rn_dl_in    = w_dl;
            rn_bnd_in   = w_bnd;
            idx_in      = '0;
            fnd_in = 1'b0;  fnd5_in = 1'b0;  nzany_in = 1'b0;  wcnt_in = '0;
            minf_in = 1'b0;  uf_in = 1'b0;  mf_in = 1'b0;  nf_in = 1'b0;
         end
         edf_pkg::ST_SCAN: begin
            if (dv_ff && !post_ff) begin
               // first release or overdue entry, pending count and earliest deadline
               if (!fnd_ff) begin
                  if (w_units == '0 && w_bnd) begin
                     fnd_in = 1'b1;
                  end else if (clock_ff != '0 && w_units != '0 && w_units < w_burst &&
                               w_bnd) begin
                     fnd_in       = 1'b1;
                     fnd5_in      = 1'b1;
                     ovd_in       = rd_idx_ff;
                     ovd_units_in = w_units;
                  end
               end
               if (w_units != '0) begin
                  nzany_in = 1'b1;
                  c0_in    = rd_idx_ff;
                  dlc0_in  = w_dl;
                  if (!run_v_ff || rd_idx_ff != run_ff) wcnt_in = wcnt_ff + CW'(1);
                  if (!minf_ff || w_dl < minv_ff) begin
                     minf_in = 1'b1;
                     minv_in = w_dl;
                     fmin_in = rd_idx_ff;
                  end
               end
            end else if (dv_ff) begin
               // candidates against the running task after a release
               if (w_units != '0 && w_dl < rn_dl_ff) begin
                  uf_in = 1'b1;
                  ui_in = rd_idx_ff;
               end
               if (rd_idx_ff < run_ff && rn_units_ff < w_units && w_dl == rn_dl_ff) begin
                  mf_in = 1'b1;
                  mi_in = rd_idx_ff;
               end
               if (w_dl == rn_dl_ff && rn_units_ff > w_units && (!nf_ff || nu_ff > w_units))
               begin
                  nf_in = 1'b1;
                  ni_in = rd_idx_ff;
                  nu_in = w_units;
               end
            end
         end
         edf_pkg::ST_DECIDE: begin
            idx_in = '0;
            case (op)
               edf_pkg::OP_IDLE: begin
                  em_en    = 1'b1;
                  clock_in = clock_ff + 32'd1;
                  dec_in   = 1'b0;
               end
               edf_pkg::OP_PICK: begin
                  em_en    = 1'b1;
                  em_data  = edf_pkg::mk_rsp(edf_pkg::EV_START, 4'(pick_c), clock_ff,
                                             16'd0, wait_ff);
                  run_v_in = 1'b1;
                  run_in   = pick_c;
               end
               edf_pkg::OP_RUN: begin
                  em_en    = 1'b1;
                  em_data  = edf_pkg::mk_rsp(edf_pkg::EV_RAN, 4'(run_ff), clock_ff,
                                             16'd0, wait_new);
                  wait_in  = wait_new;
                  clock_in = clock_ff + 32'd1;
                  dec_in   = 1'b1;
               end
               edf_pkg::OP_END: begin
                  em_en    = 1'b1;
                  em_data  = edf_pkg::mk_rsp(edf_pkg::EV_END, 4'(run_ff), clock_ff,
                                             16'd0, wait_ff);
                  run_v_in = 1'b0;
               end
               edf_pkg::OP_REL: begin
                  if (end_first) begin
                     em_en    = 1'b1;
                     em_data  = edf_pkg::mk_rsp(edf_pkg::EV_END, 4'(run_ff), clock_ff,
                                                16'd0, wait_ff);
                     run_v_in = 1'b0;
                  end else begin
                     released_in = 1'b1;
                     post5_in    = 1'b0;
                  end
               end
               default: begin
                  em_en       = 1'b1;
                  em_data     = edf_pkg::mk_rsp(edf_pkg::EV_MISS, 4'(ovd_ff), clock_ff,
                                                16'(ovd_units_ff), wait_ff);
                  released_in = 1'b1;
                  post5_in    = 1'b1;
               end
            endcase
         end
         edf_pkg::ST_RELEASE: begin
            wr_en   = dv_ff;
            post_in = run_v_ff;
         end
         edf_pkg::ST_SWITCH: begin
            post_in = 1'b0;
            if (sw) begin
               em_en   = 1'b1;
               em_data = edf_pkg::mk_rsp(edf_pkg::EV_PREEMPT, 4'(run_ff), clock_ff,
                                         16'd0, wait_ff);
               run_in  = tgt;
            end
         end
         edf_pkg::ST_START: begin
            em_en   = 1'b1;
            em_data = edf_pkg::mk_rsp(edf_pkg::EV_START, 4'(run_ff), clock_ff,
                                      16'd0, wait_ff);
         end
         edf_pkg::ST_ADVANCE: begin
            wr_en   = dv_ff;
            wr_data = {w_burst, w_period, adv_units, adv_phase};
         end
         edf_pkg::ST_NEXT: begin
            pass_in = pass_ff + 4'd1;
         end
         edf_pkg::ST_FINISH: begin
            push.en        = pend_v_ff;
            push.data      = pend_ff;
            push.data.last = 1'b1;
            pend_v_in      = 1'b0;
         end
         default: begin
         end
      endcase

      // The newest event waits in the pending slot until it is known whether it is last
      if (em_en && ecnt_ff < 4'(edf_pkg::OUT_MAX)) begin
         push.en   = pend_v_ff;
         push.data = pend_ff;
         pend_in   = em_data;
         pend_v_in = 1'b1;
         ecnt_in   = ecnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= edf_pkg::ST_IDLE;
         tcount_ff   <= 5'd1;
         horizon_ff  <= 32'hFFFF_FFFF;
         clock_ff    <= '0;
         wait_ff     <= '0;
         run_v_ff    <= 1'b0;
         valid_ff    <= '0;
         pass_ff     <= '0;
         ecnt_ff     <= '0;
         released_ff <= 1'b0;
         post_ff     <= 1'b0;
         post5_ff    <= 1'b0;
         dec_ff      <= 1'b0;
         pend_v_ff   <= 1'b0;
         dv_ff       <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         tcount_ff   <= tcount_in;
         horizon_ff  <= horizon_in;
         clock_ff    <= clock_in;
         wait_ff     <= wait_in;
         run_v_ff    <= run_v_in;
         valid_ff    <= valid_in;
         pass_ff     <= pass_in;
         ecnt_ff     <= ecnt_in;
         released_ff <= released_in;
         post_ff     <= post_in;
         post5_ff    <= post5_in;
         dec_ff      <= dec_in;
         pend_v_ff   <= pend_v_in;
         dv_ff       <= dv_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff       <= run_in;
      pend_ff      <= pend_in;
      rd_idx_ff    <= rd_addr;
      ld_idx_ff    <= ld_idx_in;
      ld_burst_ff  <= ld_burst_in;
      ld_period_ff <= ld_period_in;
      rn_units_ff  <= rn_units_in;
      rn_dl_ff     <= rn_dl_in;
      rn_bnd_ff    <= rn_bnd_in;
      fnd_ff       <= fnd_in;
      fnd5_ff      <= fnd5_in;
      ovd_ff       <= ovd_in;
      ovd_units_ff <= ovd_units_in;
      nzany_ff     <= nzany_in;
      wcnt_ff      <= wcnt_in;
      c0_ff        <= c0_in;
      dlc0_ff      <= dlc0_in;
      minf_ff      <= minf_in;
      minv_ff      <= minv_in;
      fmin_ff      <= fmin_in;
      uf_ff        <= uf_in;
      ui_ff        <= ui_in;
      mf_ff        <= mf_in;
      mi_ff        <= mi_in;
      nf_ff        <= nf_in;
      ni_ff        <= ni_in;
      nu_ff        <= nu_in;
   end

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench of the EDF periodic task scheduler: directed table, then random phases.
// Depends on edf_pkg and the RTL of edf_periodic_task_scheduler; results checked by a local predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int NTASK = 16;
   localparam logic [2:0] ADDR_TASK_COUNT = 3'd0;
   localparam logic [2:0] ADDR_HORIZON    = 3'd4;
   localparam int SETTLE = 2000;

   logic             clock;
   logic             reset;
   logic             req_valid, req_ready;
   edf_pkg::req_type req_data;
   logic             rsp_valid, rsp_ready;
   edf_pkg::rsp_type rsp_data;
   logic             csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]       csr_paddr;
   logic [31:0]      csr_pwdata, csr_prdata;

   edf_periodic_task_scheduler i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow scheduler state
   logic [15:0]     sh_burst[NTASK];
   logic [15:0]     sh_period[NTASK];
   logic [15:0]     sh_units[NTASK];
   longint unsigned sh_now;
   longint unsigned sh_wait;
   int              sh_run;
   logic [4:0]      sh_count;
   logic [31:0]     sh_horizon;

   edf_pkg::rsp_type event_q[$];   // events owed by the block, oldest first
   edf_pkg::rsp_type tick_events[$];
   int      errors;
   int      n_events;
   int      n_ticks;
   int      n_horizon;
   bit      sender_busy;
   bit      no_stall;

   // Clock and run limit
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic int active_tasks();
      return (sh_count > NTASK) ? NTASK : int'(sh_count);
   endfunction

   function automatic longint unsigned eff_period(int j);
      return (sh_period[j] != 0) ? longint'(sh_period[j]) : 1;
   endfunction

   function automatic longint unsigned deadline(int j);
      return eff_period(j) - (sh_now % eff_period(j));
   endfunction

   function automatic bit at_boundary(int j);
      return (sh_now % eff_period(j)) == 0;
   endfunction

   function automatic void note_event(logic [2:0] ev, int tsk, logic [15:0] left);
      edf_pkg::rsp_type r;
      if (tick_events.size() >= edf_pkg::OUT_MAX) return;
      r.event_res     = ev;
      r.task_res      = tsk[3:0];
      r.time_now      = sh_now[31:0];
      r.units_left    = left;
      r.waiting_total = sh_wait[31:0];
      r.last          = 1'b0;
      tick_events.push_back(r);
   endfunction

   function automatic void release_bursts(int n);
      longint unsigned s;
      for (int j = 0; j < n; j++)
         if (at_boundary(j)) begin
            s = longint'(sh_units[j]) + longint'(sh_burst[j]);
            sh_units[j] = (s > 65535) ? 16'hFFFF : s[15:0];
         end
   endfunction

   function automatic void switch_task(int u);
      if (u != sh_run && sh_units[u] != 0) begin
         note_event(edf_pkg::EV_PREEMPT, sh_run, 16'd0);
         sh_run = u;
         note_event(edf_pkg::EV_START, u, 16'd0);
      end
   endfunction

   function automatic int most_urgent(int n);
      int u;
      u = sh_run;
      for (int j = 0; j < n; j++)
         if (sh_units[j] > 0 && deadline(j) < deadline(sh_run)) u = j;
      return u;
   endfunction

   // Works out the events of one item and queues them
   function automatic void predict_item(edf_pkg::req_type it);
      int n, overdue, zeros, c, cur, u, maxp, minp;
      edf_pkg::op_type op;
      bit released, done;
      n = active_tasks();
      released = 0;
      done = 0;
      tick_events.delete();
      if (it.kind == edf_pkg::KIND_LOAD) begin
         sh_burst[it.task_index]  = it.burst;
         sh_period[it.task_index] = it.period;
         sh_units[it.task_index]  = 16'd0;
         return;
      end
      n_ticks++;
      if (sh_now >= sh_horizon) begin
         n_horizon++;
         note_event(edf_pkg::EV_HORIZON, 0, 16'd0);
      end else begin
         for (int pass = 0; pass < edf_pkg::PASS_MAX && !done &&
              tick_events.size() < edf_pkg::OUT_MAX; pass++) begin
            op = edf_pkg::OP_IDLE;
            overdue = -1;
            zeros = 0;
            if (!released)
               for (int k = 0; k < n; k++) begin
                  if (sh_units[k] == 0 && at_boundary(k)) begin
                     op = edf_pkg::OP_REL;
                     break;
                  end
                  if (sh_now > 0 && sh_units[k] > 0 && sh_units[k] < sh_burst[k] &&
                      at_boundary(k)) begin
                     op = edf_pkg::OP_MISS;
                     overdue = k;
                     break;
                  end
               end
            if (op != edf_pkg::OP_REL && op != edf_pkg::OP_MISS) begin
               if (sh_run < 0) op = edf_pkg::OP_PICK;
               else if (sh_units[sh_run] > 0) op = edf_pkg::OP_RUN;
               else op = edf_pkg::OP_END;
               for (int j = 0; j < n; j++)
                  if (sh_units[j] == 0) zeros++;
               if (zeros == n) op = (sh_run < 0) ? edf_pkg::OP_IDLE : edf_pkg::OP_END;
            end
            case (op)
               edf_pkg::OP_IDLE: begin
                  note_event(edf_pkg::EV_IDLE, 0, 16'd0);
                  sh_now++;
                  done = 1;
               end
               edf_pkg::OP_PICK: begin
                  c = 0;
                  for (int j = 0; j < n; j++)
                     if (sh_units[j] != 0) c = j;
                  for (int j = 0; j < n; j++)
                     if (sh_units[j] > 0 && deadline(j) < deadline(c)) c = j;
                  sh_run = c;
                  note_event(edf_pkg::EV_START, c, 16'd0);
               end
               edf_pkg::OP_RUN: begin
                  note_event(edf_pkg::EV_RAN, sh_run, 16'd0);
                  sh_now++;
                  sh_units[sh_run]--;
                  for (int k = 0; k < n; k++)
                     if (k != sh_run && sh_units[k] > 0 && sh_wait < 64'hFFFF_FFFF)
                        sh_wait++;
                  if (tick_events.size() > 0)
                     tick_events[tick_events.size()-1].waiting_total = sh_wait[31:0];
                  done = 1;
               end
               edf_pkg::OP_END: begin
                  note_event(edf_pkg::EV_END, sh_run, 16'd0);
                  sh_run = -1;
               end
               edf_pkg::OP_REL: begin
                  if (sh_run >= 0 && at_boundary(sh_run) && sh_units[sh_run] == 0) begin
                     note_event(edf_pkg::EV_END, sh_run, 16'd0);
                     sh_run = -1;
                     continue;
                  end
                  release_bursts(n);
                  released = 1;
                  if (sh_run >= 0) begin
                     cur = sh_run;
                     u = most_urgent(n);
                     maxp = -1;
                     minp = -1;
                     // equal deadline: a lower index with more work left wins
                     for (int j = 0; j < cur && j < n; j++)
                        if (sh_units[cur] < sh_units[j] && deadline(j) == deadline(cur))
                           maxp = j;
                     // otherwise the equal-deadline task with least work left
                     if (maxp < 0 && u == cur)
                        for (int j = 0; j < n; j++)
                           if (deadline(cur) == deadline(j) && sh_units[cur] > sh_units[j])
                              if (minp < 0 || sh_units[minp] > sh_units[j]) minp = j;
                     if (maxp >= 0) u = maxp;
                     if (minp >= 0) u = minp;
                     switch_task(u);
                  end
               end
               default: begin
                  note_event(edf_pkg::EV_MISS, overdue, sh_units[overdue]);
                  release_bursts(n);
                  released = 1;
                  if (sh_run >= 0) switch_task(most_urgent(n));
               end
            endcase
         end
      end
      if (tick_events.size() > 0) tick_events[tick_events.size()-1].last = 1'b1;
      foreach (tick_events[i]) event_q.push_back(tick_events[i]);
   endfunction

   // ---------------- result check ----------------
   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      edf_pkg::rsp_type e;
      if (!reset) begin
         rsp_ready <= no_stall || ($urandom_range(99) >= 25);
         if (rsp_valid && rsp_ready) begin
            n_events++;
            if (event_q.size() == 0) begin
               errors++;
               $error("event with none pending: 0x%0h", rsp_data);
            end else begin
               e = event_q.pop_front();
               check_field("event_res", e.event_res, rsp_data.event_res);
               check_field("task_res", e.task_res, rsp_data.task_res);
               check_field("time_now", e.time_now, rsp_data.time_now);
               check_field("units_left", e.units_left, rsp_data.units_left);
               check_field("waiting_total", e.waiting_total, rsp_data.waiting_total);
               check_field("last", e.last, rsp_data.last);
            end
         end
      end
   end

   // ---------------- drivers ----------------
   task automatic wait_drained();
      while (event_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_TASK_COUNT) sh_count = value[4:0];
      else sh_horizon = value;
   endtask

   // Block goes idle, then both registers are rewritten
   task automatic reconfigure(logic [4:0] count, logic [31:0] hz);
      if (sender_busy) begin
         req_valid <= 1'b0;
         sender_busy = 0;
      end
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_write(ADDR_TASK_COUNT, {27'd0, count});
      csr_write(ADDR_HORIZON, hz);
      @(posedge clock);
   endtask

   // Offers one item; typed events replace the predicted ones when given
   task automatic send_item(edf_pkg::req_type it, int n_typed, edf_pkg::rsp_type t0,
                            edf_pkg::rsp_type t1, bit may_idle);
      int gap;
      req_valid <= 1'b1;
      req_data  <= it;
      sender_busy = 1;
      do @(posedge clock); while (!req_ready);
      predict_item(it);
      if (n_typed > 0) begin
         repeat (tick_events.size()) void'(event_q.pop_back());
         event_q.push_back(t0);
         if (n_typed > 1) event_q.push_back(t1);
      end
      if (may_idle && $urandom_range(99) < 25) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         sender_busy = 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic edf_pkg::req_type load_item(int idx, int b, int p);
      edf_pkg::req_type r;
      r.kind       = edf_pkg::KIND_LOAD;
      r.task_index = idx[3:0];
      r.burst      = b[15:0];
      r.period     = p[15:0];
      return r;
   endfunction

   function automatic edf_pkg::req_type tick_item();
      edf_pkg::req_type r;
      r.kind       = edf_pkg::KIND_TICK;
      r.task_index = 4'($urandom_range(15));
      r.burst      = 16'($urandom_range(1, 65535));
      r.period     = 16'($urandom_range(1, 65535));
      return r;
   endfunction

   function automatic edf_pkg::req_type random_item();
      int b, p;
      if ($urandom_range(99) < 80) return tick_item();
      b = ($urandom_range(19) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 4);
      p = ($urandom_range(19) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 12);
      return load_item($urandom_range(15), b, p);
   endfunction

   // ---------------- stimulus ----------------
   typedef struct {
      edf_pkg::req_type item;
      int               n_typed;
      edf_pkg::rsp_type t0;
      edf_pkg::rsp_type t1;
   } row_type;

   row_type rows[$];
   int      bursts[NTASK]  = '{1, 2, 1, 3, 1, 2, 1, 4, 1, 2, 1, 3, 1, 2, 1, 65535};
   int      periods[NTASK] = '{1, 4, 3, 6, 5, 8, 2, 12, 7, 9, 10, 16, 6, 5, 4, 65535};

   initial begin
      row_type r;
      edf_pkg::rsp_type nil;
      nil = '0;
      errors = 0;
      n_events = 0;
      n_ticks = 0;
      n_horizon = 0;
      sender_busy = 0;
      no_stall = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      foreach (sh_units[i]) begin
         sh_units[i] = '0;
         sh_burst[i] = '0;
         sh_period[i] = '0;
      end
      sh_now = 0;
      sh_wait = 0;
      sh_run = -1;
      sh_count = 5'd1;
      sh_horizon = 32'hFFFF_FFFF;

      // Directed table: first tick after reset is read off directly
      r = '{load_item(0, 1, 1), 0, nil, nil};
      rows.push_back(r);
      r = '{tick_item(), 2,
            edf_pkg::mk_rsp(edf_pkg::EV_START, 4'd0, 32'd0, 16'd0, 32'd0),
            edf_pkg::mk_rsp(edf_pkg::EV_RAN, 4'd0, 32'd0, 16'd0, 32'd0)};
      r.t1.last = 1'b1;
      rows.push_back(r);
      for (int i = 1; i < NTASK; i++) begin
         r = '{load_item(i, bursts[i], periods[i]), 0, nil, nil};
         rows.push_back(r);
      end
      for (int i = 0; i < 6; i++) begin
         r = '{tick_item(), 0, nil, nil};
         rows.push_back(r);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_item(rows[i].item, rows[i].n_typed, rows[i].t0, rows[i].t1, 1);

      // Random phases over several register settings
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: reconfigure(5'd16, 32'hFFFF_FFFF);
            1: reconfigure(5'd1, 32'hFFFF_FFFF);
            2: reconfigure(5'd16, sh_now[31:0] + $urandom_range(3, 12));
            3: reconfigure(5'd16, 32'd1);
            4: reconfigure(5'($urandom_range(2, 15)), 32'hFFFF_FFFF);
            5: reconfigure(5'd8, 32'hFFFF_FFFF);
            default: reconfigure(5'($urandom_range(1, 16)), 32'hFFFF_FFFF);
         endcase
         no_stall = (ph == 0);
         for (int i = 0; i < 34; i++) begin
            if (ph == 4 && i == 17) begin
               // hold off until every owed event has been taken
               if (sender_busy) begin
                  req_valid <= 1'b0;
                  sender_busy = 0;
               end
               wait_drained();
            end
            send_item(random_item(), 0, nil, nil, ph != 0);
         end
      end
      no_stall = 0;
      if (sender_busy) req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE) @(posedge clock);

      $display("Covered %0d ticks (%0d past horizon) and %0d checked events", n_ticks,
               n_horizon, n_events);
      $display("over task counts 1..16 and horizons from 1 to the maximum.");
      if (errors == 0 && event_q.size() == 0) begin
         $display("PASS");
      end else begin
         if (event_q.size() != 0) $error("%0d events never arrived", event_q.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
